// ===== rtl/psq_pkg.sv =====
package psq_pkg;

  localparam int ENTRIES = 64;
  localparam int DIMS = 2;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int ID_W = 16;
  localparam int CO_W = 16;
  localparam int K_W = 7;
  localparam int DIST_W = 32 + ((DIMS > 1) ? $clog2(DIMS) : 0);
  localparam int KEY_W = DIST_W + ID_W + IDX_W;

  typedef enum logic [1:0] {
    K_CLEAR  = 2'd0,
    K_APPEND = 2'd1,
    K_RANGE  = 2'd2,
    K_KNN    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_KEMIT
  } state_t;

endpackage

// ===== rtl/point_store_range_and_knn_query_core.sv =====
// Point store with box range search and k-nearest search.
// Input: a transaction is accepted at a rising edge with start high and busy low.
// Clear and append complete in the accepting cycle and leave busy low, so a
// new transaction can follow in the next cycle.
// A range query scans the stored entries once in load order; matching ids are
// reported in load order, each held back until the next hit or the scan's end.
// A k-nearest query makes one scan over the store per reported neighbour, or a
// single scan when it reports none. The scan rate is set by the single read
// port of the point memory: one entry a cycle.
// Each result appears for one cycle with out_valid high; last marks the final
// result of a query. A query with no hits gives one result with found low.
// The receiver cannot stall the block; results are never held back.
// Reset clears the entry count and the controller; the point memories are not
// cleared, since entries at or beyond the count are never used.
module point_store_range_and_knn_query_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_kind,
  input  logic [15:0]               in_item_id,
  input  logic signed [15:0]        in_coord_0,
  input  logic signed [15:0]        in_coord_1,
  input  logic signed [15:0]        in_coord_2,
  input  logic signed [15:0]        in_coord_3,
  input  logic signed [15:0]        in_upper_0,
  input  logic signed [15:0]        in_upper_1,
  input  logic signed [15:0]        in_upper_2,
  input  logic signed [15:0]        in_upper_3,
  input  logic [psq_pkg::K_W-1:0]   in_neighbour_count,
  output logic                      out_valid,
  output logic [15:0]               out_result_id,
  output logic                      out_found,
  output logic                      out_last
);
  import psq_pkg::*;

  logic [ID_W-1:0]        id_mem [ENTRIES];
  logic [DIMS*CO_W-1:0]   co_mem [ENTRIES];

  logic signed [CO_W-1:0] lo_in [4];
  logic signed [CO_W-1:0] hi_in [4];
  logic signed [CO_W-1:0] q_lo_r [DIMS];
  logic signed [CO_W-1:0] q_hi_r [DIMS];

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] addr_r, addr_nxt;
  logic [CNT_W-1:0] keff_r, keff_nxt;
  logic [CNT_W-1:0] rank_r, rank_nxt;
  logic             knn_r, knn_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]  pend_id_r, pend_id_nxt;
  logic             best_v_r, best_v_nxt;
  logic [KEY_W-1:0] best_key_r, best_key_nxt;
  logic             prev_v_r, prev_v_nxt;
  logic [KEY_W-1:0] prev_key_r, prev_key_nxt;
  logic             ov_r, ov_nxt;
  logic [ID_W-1:0]  oid_r, oid_nxt;
  logic             ofound_r, ofound_nxt;
  logic             olast_r, olast_nxt;

  logic                 v1_r, v2_r;
  logic [IDX_W-1:0]     idx1_r, idx2_r;
  logic [ID_W-1:0]      rd_id_r, id2_r;
  logic [DIMS*CO_W-1:0] rd_co_r;
  logic [DIST_W-1:0]    dist2_r, dist_c;
  logic                 inside2_r, inside_c;
  logic [KEY_W-1:0]     key2;

  logic issue, scan_done, accept, wr_en, load_q, cand, is_last;
  logic [DIMS*CO_W-1:0] wr_co;
  logic [CNT_W-1:0] k_lim;

  assign lo_in[0] = in_coord_0;
  assign lo_in[1] = in_coord_1;
  assign lo_in[2] = in_coord_2;
  assign lo_in[3] = in_coord_3;
  assign hi_in[0] = in_upper_0;
  assign hi_in[1] = in_upper_1;
  assign hi_in[2] = in_upper_2;
  assign hi_in[3] = in_upper_3;

  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      wr_co[d*CO_W +: CO_W] = lo_in[d];
    end
  end

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign wr_en   = accept && (kind_t'(in_kind) == K_APPEND) && (count_r < CNT_W'(ENTRIES));
  assign load_q  = accept && in_kind[1];
  assign issue   = (state_r == S_SCAN) && (addr_r < count_r);
  assign scan_done = (state_r == S_SCAN) && !issue && !v1_r && !v2_r;
  assign key2    = {dist2_r, id2_r, idx2_r};
  assign k_lim   = (in_neighbour_count > K_W'(count_r)) ? count_r :
                   CNT_W'(in_neighbour_count);
  // Keys are unique (index is part of them), so each pass takes the smallest key
  // above the one reported last; no per-entry used flags are needed.
  assign cand    = (!prev_v_r || key2 > prev_key_r) && (!best_v_r || key2 < best_key_r);
  assign is_last = (rank_r == keff_r - CNT_W'(1));

  // Memory writes happen only while idle, and read data is used only during a
  // scan, so a write never changes an entry that a running scan uses.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[count_r[IDX_W-1:0]] <= in_item_id;
      co_mem[count_r[IDX_W-1:0]] <= wr_co;
    end
    rd_id_r <= id_mem[addr_r[IDX_W-1:0]];
    rd_co_r <= co_mem[addr_r[IDX_W-1:0]];
  end

  always_comb begin
    logic signed [CO_W:0]     diff;
    logic signed [2*CO_W+1:0] sq;
    logic signed [CO_W-1:0]   c;
    dist_c   = '0;
    inside_c = 1'b1;
    for (int d = 0; d < DIMS; d++) begin
      c    = rd_co_r[d*CO_W +: CO_W];
      diff = {c[CO_W-1], c} - {q_lo_r[d][CO_W-1], q_lo_r[d]};
      sq   = diff * diff;
      dist_c = dist_c + DIST_W'(sq[2*CO_W-1:0]);
      if (c < q_lo_r[d] || c > q_hi_r[d]) begin
        inside_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_q) begin
      for (int d = 0; d < DIMS; d++) begin
        q_lo_r[d] <= lo_in[d];
        q_hi_r[d] <= hi_in[d];
      end
    end
    idx1_r    <= addr_r[IDX_W-1:0];
    idx2_r    <= idx1_r;
    id2_r     <= rd_id_r;
    dist2_r   <= dist_c;
    inside2_r <= inside_c;
    pend_id_r  <= pend_id_nxt;
    best_key_r <= best_key_nxt;
    prev_key_r <= prev_key_nxt;
    oid_r      <= oid_nxt;
    ofound_r   <= ofound_nxt;
    olast_r    <= olast_nxt;
    addr_r     <= addr_nxt;
    keff_r     <= keff_nxt;
    rank_r     <= rank_nxt;
    knn_r      <= knn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      pend_v_r <= 1'b0;
      best_v_r <= 1'b0;
      prev_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      v1_r     <= issue;
      v2_r     <= v1_r;
      pend_v_r <= pend_v_nxt;
      best_v_r <= best_v_nxt;
      prev_v_r <= prev_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    keff_nxt     = keff_r;
    rank_nxt     = rank_r;
    knn_nxt      = knn_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    best_v_nxt   = best_v_r;
    best_key_nxt = best_key_r;
    prev_v_nxt   = prev_v_r;
    prev_key_nxt = prev_key_r;
    ov_nxt       = 1'b0;
    oid_nxt      = '0;
    ofound_nxt   = 1'b0;
    olast_nxt    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind_t'(in_kind))
            K_CLEAR: count_nxt = '0;
            K_APPEND: begin
              if (wr_en) begin
                count_nxt = count_r + CNT_W'(1);
              end
            end
            default: begin
              addr_nxt   = '0;
              pend_v_nxt = 1'b0;
              best_v_nxt = 1'b0;
              prev_v_nxt = 1'b0;
              rank_nxt   = '0;
              keff_nxt   = k_lim;
              knn_nxt    = (kind_t'(in_kind) == K_KNN);
              state_nxt  = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          addr_nxt = addr_r + CNT_W'(1);
        end
        if (v2_r) begin
          if (!knn_r) begin
            if (inside2_r) begin
              // A hit is held back until the next hit or the scan's end so the final one can carry last.
              if (pend_v_r) begin
                ov_nxt     = 1'b1;
                oid_nxt    = pend_id_r;
                ofound_nxt = 1'b1;
              end
              pend_id_nxt = id2_r;
              pend_v_nxt  = 1'b1;
            end
          end else if (cand) begin
            best_key_nxt = key2;
            best_v_nxt   = 1'b1;
          end
        end
        if (scan_done) begin
          state_nxt = knn_r ? S_KEMIT : S_FLUSH;
        end
      end
      S_FLUSH: begin
        ov_nxt     = 1'b1;
        oid_nxt    = pend_v_r ? pend_id_r : '0;
        ofound_nxt = pend_v_r;
        olast_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_KEMIT: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        state_nxt = S_IDLE;
        if (keff_r != '0) begin
          oid_nxt      = best_key_r[IDX_W +: ID_W];
          ofound_nxt   = 1'b1;
          olast_nxt    = is_last;
          prev_key_nxt = best_key_r;
          prev_v_nxt   = 1'b1;
          best_v_nxt   = 1'b0;
          rank_nxt     = rank_r + CNT_W'(1);
          addr_nxt     = '0;
          if (!is_last) begin
            state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid     = ov_r;
  assign out_result_id = oid_r;
  assign out_found     = ofound_r;
  assign out_last      = olast_r;

endmodule

// ===== rtl/psq_checker.sv =====
module psq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic       out_found,
  input logic       out_last
);

  // An empty answer is always the only result of its query.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("empty result without last");

  // Clear and append never make the block busy.
  a_store_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_kind[1] |=> !busy)
    else $error("store transaction left block busy");

  // A query keeps the block busy in the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind[1] |=> busy)
    else $error("query transaction not started");

  // Nothing follows the last result in the next cycle.
  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result directly after last");

  // A result without last means the query is still running.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("intermediate result while idle");

endmodule

bind point_store_range_and_knn_query_core psq_checker u_psq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_found (out_found),
  .out_last  (out_last)
);

// ===== test/point_store_range_and_knn_query_core_test.sv =====
`timescale 1ns / 1ps

module point_store_range_and_knn_query_core_test;
  import psq_pkg::*;

  typedef struct packed {
    logic [15:0] id;
    logic        found;
    logic        last;
  } answer_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] id;
    logic [15:0] lo0, lo1, hi0, hi1;
    logic [6:0]  k;
    bit          typed;
    logic [15:0] want_id;
    logic        want_found;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_kind = K_CLEAR;
  logic [15:0] in_item_id = '0;
  logic signed [15:0] in_coord_0 = '0, in_coord_1 = '0, in_coord_2 = '0, in_coord_3 = '0;
  logic signed [15:0] in_upper_0 = '0, in_upper_1 = '0, in_upper_2 = '0, in_upper_3 = '0;
  logic [K_W-1:0] in_neighbour_count = '0;
  logic        out_valid;
  logic [15:0] out_result_id;
  logic        out_found;
  logic        out_last;

  // Shadow copy of the point store.
  logic [15:0]        pt_id [ENTRIES];
  logic signed [15:0] pt_x [ENTRIES];
  logic signed [15:0] pt_y [ENTRIES];
  int                 pt_count = 0;

  answer_t pending_answers[$];
  answer_t fresh[$];
  bit      failed = 1'b0;

  point_store_range_and_knn_query_core uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Works out the answers of one accepted transaction and queues them in fresh.
  task automatic answer_transaction(kind_t kind, logic [15:0] id, logic signed [15:0] lo0,
                                    logic signed [15:0] lo1, logic signed [15:0] hi0,
                                    logic signed [15:0] hi1, logic [6:0] k);
    bit             taken [ENTRIES];
    longint         sq_d [ENTRIES];
    longint         dx, dy;
    int             best, lim;
    answer_t        a;
    fresh.delete();
    case (kind)
      K_CLEAR: pt_count = 0;
      K_APPEND: begin
        if (pt_count < ENTRIES) begin
          pt_id[pt_count] = id;
          pt_x[pt_count] = lo0;
          pt_y[pt_count] = lo1;
          pt_count++;
        end
      end
      K_RANGE: begin
        for (int e = 0; e < pt_count; e++)
          if (pt_x[e] >= lo0 && pt_x[e] <= hi0 && pt_y[e] >= lo1 && pt_y[e] <= hi1) begin
            a = '{pt_id[e], 1'b1, 1'b0};
            fresh.push_back(a);
          end
      end
      default: begin
        for (int e = 0; e < pt_count; e++) begin
          dx = longint'(pt_x[e]) - longint'(lo0);
          dy = longint'(pt_y[e]) - longint'(lo1);
          sq_d[e] = dx * dx + dy * dy;
          taken[e] = 1'b0;
        end
        lim = (k > pt_count) ? pt_count : k;
        for (int r = 0; r < lim; r++) begin
          best = -1;
          for (int e = 0; e < pt_count; e++)
            if (!taken[e] && (best < 0 || sq_d[e] < sq_d[best] ||
                (sq_d[e] == sq_d[best] && pt_id[e] < pt_id[best])))
              best = e;
          taken[best] = 1'b1;
          a = '{pt_id[best], 1'b1, 1'b0};
          fresh.push_back(a);
        end
      end
    endcase
    if (kind == K_RANGE || kind == K_KNN) begin
      if (fresh.size() == 0) begin
        a = '{16'd0, 1'b0, 1'b1};
        fresh.push_back(a);
      end else begin
        fresh[fresh.size() - 1].last = 1'b1;
      end
    end
  endtask

  // Drives one transaction and holds it until the block takes it.
  task automatic send(kind_t kind, logic [15:0] id, logic signed [15:0] lo0,
                      logic signed [15:0] lo1, logic signed [15:0] hi0,
                      logic signed [15:0] hi1, logic [6:0] k);
    in_kind <= kind;
    in_item_id <= id;
    in_coord_0 <= lo0;
    in_coord_1 <= lo1;
    in_coord_2 <= 16'($urandom);
    in_coord_3 <= 16'($urandom);
    in_upper_0 <= hi0;
    in_upper_1 <= hi1;
    in_upper_2 <= 16'($urandom);
    in_upper_3 <= 16'($urandom);
    in_neighbour_count <= k;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    answer_transaction(kind, id, lo0, lo1, hi0, hi1, k);
    foreach (fresh[i]) pending_answers.push_back(fresh[i]);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id=%h found=%b last=%b",
                 $time, out_result_id, out_found, out_last);
        failed <= 1'b1;
      end else begin
        if (pending_answers[0].id !== out_result_id)
          $display("%0t: result_id mismatch, expected %h, actual %h",
                   $time, pending_answers[0].id, out_result_id);
        if (pending_answers[0].found !== out_found)
          $display("%0t: found mismatch, expected %b, actual %b",
                   $time, pending_answers[0].found, out_found);
        if (pending_answers[0].last !== out_last)
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, pending_answers[0].last, out_last);
        if (pending_answers[0] !== {out_result_id, out_found, out_last})
          failed <= 1'b1;
        void'(pending_answers.pop_front());
      end
    end
  end

  row_t directed [] = '{
    '{K_RANGE,  16'h0000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 7'd0, 1, 16'h0, 1'b0},
    '{K_KNN,    16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd5, 1, 16'h0, 1'b0},
    '{K_APPEND, 16'hffff, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_APPEND, 16'h0000, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_APPEND, 16'h0007, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_APPEND, 16'h0003, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_APPEND, 16'h0007, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_APPEND, 16'h5a5a, 16'sh0100, 16'shff00, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_RANGE,  16'h0000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 7'd0, 0, 16'h0, 1'b0},
    '{K_RANGE,  16'h0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 7'd0, 1, 16'h0, 1'b1},
    '{K_RANGE,  16'h0000, 16'sh8000, 16'sh0001, 16'sh7fff, 16'sh0000, 7'd0, 1, 16'h0, 1'b0},
    '{K_RANGE,  16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_KNN,    16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd0, 1, 16'h0, 1'b0},
    '{K_KNN,    16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd64, 0, 16'h0, 1'b0},
    '{K_KNN,    16'h0000, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000, 7'd2, 0, 16'h0, 1'b0},
    '{K_KNN,    16'h0000, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000, 7'd1, 1, 16'h0, 1'b1},
    '{K_KNN,    16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd3, 0, 16'h0, 1'b0},
    '{K_CLEAR,  16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd0, 0, 16'h0, 1'b0},
    '{K_RANGE,  16'h0000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 7'd0, 1, 16'h0, 1'b0},
    '{K_KNN,    16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 7'd64, 1, 16'h0, 1'b0}
  };

  initial begin
    int                 items, fill, picked;
    logic signed [15:0] lo0, lo1, hi0, hi1;
    kind_t              kind;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send(directed[i].kind, directed[i].id, directed[i].lo0, directed[i].lo1,
           directed[i].hi0, directed[i].hi1, directed[i].k);
      if (directed[i].typed && (fresh.size() != 1 || fresh[0].found !== directed[i].want_found ||
          (directed[i].want_found && fresh[0].id !== directed[i].want_id))) begin
        $display("%0t: directed row %0d, expected id=%h found=%b, predicted otherwise",
                 $time, i, directed[i].want_id, directed[i].want_found);
        failed = 1'b1;
      end
    end

    // Each phase may clear the store, appends points to it and then sends mostly queries.
    items = 0;
    while (items < 450) begin
      if (items > 60 && items < 80) begin
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
      end
      fill = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        send(K_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 7'($urandom));
        items++;
      end
      for (int n = 0; n < fill + $urandom_range(3, 8); n++) begin
        kind = (n < fill) ? K_APPEND : kind_t'($urandom_range(0, 9) == 0 ? $urandom_range(0, 3)
                                                                           : $urandom_range(2, 3));
        lo0 = pick_coord();
        lo1 = pick_coord();
        if (kind != K_APPEND && pt_count > 0 && $urandom_range(0, 1)) begin
          picked = $urandom_range(0, pt_count - 1);
          lo0 = pt_x[picked] - 16'($urandom_range(0, 3));
          lo1 = pt_y[picked] - 16'($urandom_range(0, 3));
        end
        hi0 = $urandom_range(0, 5) == 0 ? pick_coord() : lo0 + 16'($urandom_range(0, 20000));
        hi1 = $urandom_range(0, 5) == 0 ? pick_coord() : lo1 + 16'($urandom_range(0, 20000));
        if (hi0 < lo0 && $urandom_range(0, 1)) hi0 = 16'sh7fff;
        if (hi1 < lo1 && $urandom_range(0, 1)) hi1 = 16'sh7fff;
        send(kind, $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 15)),
             lo0, lo1, hi0, hi1,
             7'($urandom_range(0, 9) == 0 ? $urandom_range(0, 64) : $urandom_range(0, 6)));
        items++;
        if (items < 400 && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
      end
    end
    start <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $display("%0t: %0d results never arrived, expected id=%h, actual none",
               $time, pending_answers.size(), pending_answers[0].id);
      failed = 1'b1;
    end
    if (!failed) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== point_store_range_and_knn_query_core.f =====
rtl/psq_pkg.sv
rtl/point_store_range_and_knn_query_core.sv
rtl/psq_checker.sv
test/point_store_range_and_knn_query_core_test.sv
